FILE: rtl/efa_pkg.sv
`timescale 1ns / 1ps
package efa_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] MODE_POL   = 3'd0;
  localparam logic [2:0] MODE_CNT16 = 3'd1;
  localparam logic [2:0] MODE_CNT8  = 3'd2;
  localparam logic [2:0] MODE_TSURF = 3'd3;
  localparam logic [2:0] MODE_BILIN = 3'd4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_TOFF   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       wr;
    logic       clr_wr;
    logic       clr_inc;
    logic [1:0] nb;
    logic       out_stb;
  } efa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic nb_ok;
  } efa_sts_t;
endpackage

FILE: rtl/event_frame_accumulator.sv
`timescale 1ns / 1ps
// Event frame accumulator: pixel store of MAX_WIDTH x MAX_HEIGHT 32-bit words.
// Request channel: start with in_operation and fields; taken when busy is low.
//   clear: accept, then a sweep of one word a cycle through the whole store.
//   accumulate: accept, then a read and a write per word on the single-port
//     memory; bilinear mode visits four words.
//   read: out_valid strobes one cycle with out_pixel_word, in the same cycle
//     that busy drops.
// Accumulate requests with inside_req low or an unused mode, and unused
//   operations, go straight back to idle; an event outside the frame stops after its first read.
// Reset: registers go to defaults and the store is cleared by the same sweep,
//   with busy high. Config writes are always taken.
// Results cannot be stalled; they are valid for exactly one cycle.
// Registers at cfg byte address 0 mode, 4 width, 8 height, 12 time offset.
module event_frame_accumulator import efa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [16:0] in_x_pos,
  input  logic [16:0] in_y_pos,
  input  logic        in_inside_req,
  input  logic        in_polarity,
  input  logic [15:0] in_time_delta,
  output logic        out_valid,
  output logic [31:0] out_pixel_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  cfg_mode_r;
  logic [8:0]  cfg_width_r, cfg_height_r;
  logic [15:0] cfg_toff_r;
  efa_cmd_t    cmd;
  efa_sts_t    sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= MODE_CNT16;
      cfg_width_r <= 9'd240;
      cfg_height_r <= 9'd180;
      cfg_toff_r <= 16'd6554;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MODE:   cfg_mode_r <= pwdata[2:0];
        REG_WIDTH:  cfg_width_r <= pwdata[8:0];
        REG_HEIGHT: cfg_height_r <= pwdata[8:0];
        REG_TOFF:   cfg_toff_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {29'd0, cfg_mode_r};
      REG_WIDTH:  prdata = {23'd0, cfg_width_r};
      REG_HEIGHT: prdata = {23'd0, cfg_height_r};
      default:    prdata = {16'd0, cfg_toff_r};
    endcase
  end

  efa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_operation),
    .in_view(in_inside_req), .mode(cfg_mode_r), .sts(sts), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  efa_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_x_pos(in_x_pos),
    .in_y_pos(in_y_pos), .in_polarity(in_polarity), .in_time_delta(in_time_delta),
    .mode(cfg_mode_r), .frame_width(cfg_width_r), .frame_height(cfg_height_r),
    .time_offset(cfg_toff_r), .out_pixel_word(out_pixel_word)
  );
endmodule

FILE: rtl/efa_datapath.sv
`timescale 1ns / 1ps
module efa_datapath import efa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  efa_cmd_t    cmd,
  output efa_sts_t    sts,
  input  logic [16:0] in_x_pos,
  input  logic [16:0] in_y_pos,
  input  logic        in_polarity,
  input  logic [15:0] in_time_delta,
  input  logic [2:0]  mode,
  input  logic [8:0]  frame_width,
  input  logic [8:0]  frame_height,
  input  logic [15:0] time_offset,
  output logic [31:0] out_pixel_word
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int CW = XW > 10 ? XW + 1 : 11;

  logic [31:0] mem [2**AW];
  logic [31:0] rdata_r;
  logic [CW-1:0] xi_r, yi_r;
  logic [7:0]  fx_r, fy_r;
  logic        pol_r;
  logic [15:0] td_r;
  logic [AW-1:0] clr_addr_r;
  logic [31:0] out_r;
  logic [CW-1:0] aw_c, ah_c, nx, ny;
  logic [AW-1:0] addr;
  logic [8:0]  wx, wy;
  logic [17:0] wgt;
  logic [32:0] sum;
  logic [31:0] wdata;

  always_comb begin
    aw_c = (CW'(frame_width) < CW'(MAX_WIDTH)) ? CW'(frame_width) : CW'(MAX_WIDTH);
    ah_c = (CW'(frame_height) < CW'(MAX_HEIGHT)) ? CW'(frame_height) : CW'(MAX_HEIGHT);
    nx = xi_r + CW'(cmd.nb[0]);
    ny = yi_r + CW'(cmd.nb[1]);
    sts.nb_ok = !nx[CW-1] && !ny[CW-1] && nx < aw_c && ny < ah_c;
    sts.clr_done = &clr_addr_r;
    addr = {ny[YW-1:0], nx[XW-1:0]};
    wx = cmd.nb[0] ? {1'b0, fx_r} : 9'd256 - {1'b0, fx_r};
    wy = cmd.nb[1] ? {1'b0, fy_r} : 9'd256 - {1'b0, fy_r};
    wgt = wx * wy;
    sum = {1'b0, rdata_r} + 33'(wgt);
    case (mode)
      MODE_POL:   wdata = pol_r ? {rdata_r[31:16] + 16'd1, rdata_r[15:0]}
                                : {rdata_r[31:16], rdata_r[15:0] + 16'd1};
      MODE_CNT16: wdata = {16'd0, rdata_r[15:0] + 16'd1};
      MODE_CNT8:  wdata = {24'd0, rdata_r[7:0] + 8'd1};
      MODE_TSURF: wdata = {16'd0, time_offset} - {16'd0, td_r};
      default:    wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.load) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_inc) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xi_r  <= CW'($signed(in_x_pos[16:8]));
      yi_r  <= CW'($signed(in_y_pos[16:8]));
      fx_r  <= in_x_pos[7:0];
      fy_r  <= in_y_pos[7:0];
      pol_r <= in_polarity;
      td_r  <= in_time_delta;
    end
    if (cmd.rd) rdata_r <= mem[addr];
    if (cmd.clr_wr) mem[clr_addr_r] <= '0;
    else if (cmd.wr) mem[addr] <= wdata;
    if (cmd.out_stb) out_r <= sts.nb_ok ? rdata_r : 32'd0;
  end

  assign out_pixel_word = out_r;
endmodule

FILE: rtl/efa_ctrl.sv
`timescale 1ns / 1ps
module efa_ctrl import efa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  input  logic       in_view,
  input  logic [2:0] mode,
  input  efa_sts_t   sts,
  output efa_cmd_t   cmd,
  output logic       busy,
  output logic       out_valid
);
  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_RD, S_WR, S_RDOUT, S_OUT} state_t;
  state_t     state_r;
  logic [1:0] nb_r;
  logic       oval_r;
  op_t        opc;

  assign opc = op_t'(op);
  assign busy = state_r != S_IDLE;
  assign out_valid = oval_r;

  always_comb begin
    cmd = '0;
    cmd.nb = nb_r;
    cmd.load = state_r == S_IDLE && start;
    case (state_r)
      S_CLEAR: begin cmd.clr_wr = 1'b1; cmd.clr_inc = 1'b1; end
      S_RD:    cmd.rd = sts.nb_ok;
      S_RDOUT: cmd.rd = 1'b1;
      S_WR:    cmd.wr = sts.nb_ok;
      S_OUT:   cmd.out_stb = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      nb_r <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      oval_r <= state_r == S_OUT;
      case (state_r)
        S_IDLE: if (start) begin
          nb_r <= 2'd0;
          case (opc)
            OP_CLEAR: state_r <= S_CLEAR;
            OP_ACCUM: state_r <= (in_view && mode <= MODE_BILIN) ? S_RD : S_IDLE;
            OP_READ:  state_r <= S_RDOUT;
            default:  state_r <= S_IDLE;
          endcase
        end
        S_CLEAR: if (sts.clr_done) state_r <= S_IDLE;
        S_RD: state_r <= (nb_r == 2'd0 && !sts.nb_ok) ? S_IDLE : S_WR;
        S_WR: begin
          if (mode == MODE_BILIN && nb_r != 2'd3) begin
            nb_r <= nb_r + 2'd1;
            state_r <= S_RD;
          end else state_r <= S_IDLE;
        end
        S_RDOUT: state_r <= S_OUT;
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |=> !oval_r) else $error("strobe longer than one cycle");
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> $past(state_r) == S_RDOUT) else $error("bad read path");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> $past(state_r) == S_RD) else $error("write without read");
`endif
endmodule
